### design/tgp_pkg.sv
`default_nettype none

package tgp_pkg;

  // Command codes on the mode input
  localparam logic [2:0] MODE_PEN_UP   = 3'd0;
  localparam logic [2:0] MODE_PEN_DOWN = 3'd1;
  localparam logic [2:0] MODE_TURN_INC = 3'd2;
  localparam logic [2:0] MODE_TURN_DEC = 3'd3;
  localparam logic [2:0] MODE_FORWARD  = 3'd4;
  localparam logic [2:0] MODE_PRINT    = 3'd5;

  // Headings
  localparam logic [1:0] HEAD_EAST  = 2'd0;
  localparam logic [1:0] HEAD_SOUTH = 2'd1;
  localparam logic [1:0] HEAD_WEST  = 2'd2;
  localparam logic [1:0] HEAD_NORTH = 2'd3;

  localparam int ROW_W  = 32;
  localparam int DIST_W = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PRINT
  } tgp_state_t;

  typedef struct packed {
    logic set_pen;
    logic pen_val;
    logic turn_inc;
    logic turn_dec;
    logic load_steps;
    logic step;
    logic emit_row;
  } tgp_cmd_t;

  typedef struct packed {
    logic blocked;
    logic final_step;
    logic final_row;
  } tgp_stat_t;

endpackage

`default_nettype wire

### design/tgp_ctrl.sv
`default_nettype none

module tgp_ctrl
  import tgp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2:0]        mode,
  input  wire logic [DIST_W-1:0] distance,
  input  wire tgp_stat_t         stat,
  output tgp_cmd_t               cmd,
  output logic                   busy
);

  tgp_state_t state;
  tgp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_PEN_UP: begin
              cmd.set_pen = 1'b1;
              cmd.pen_val = 1'b0;
            end
            MODE_PEN_DOWN: begin
              cmd.set_pen = 1'b1;
              cmd.pen_val = 1'b1;
            end
            MODE_TURN_INC: cmd.turn_inc = 1'b1;
            MODE_TURN_DEC: cmd.turn_dec = 1'b1;
            MODE_FORWARD: begin
              // zero distance: nothing to walk
              if (distance != '0) begin
                cmd.load_steps = 1'b1;
                state_next     = ST_WALK;
              end
            end
            MODE_PRINT: state_next = ST_PRINT;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        // drop the remaining steps once the edge is reached
        if (stat.blocked || stat.final_step) begin
          state_next = ST_IDLE;
        end
      end
      ST_PRINT: begin
        cmd.emit_row = 1'b1;
        if (stat.final_row) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### design/tgp_datapath.sv
`default_nettype none

module tgp_datapath
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 32
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [DIST_W-1:0] distance,
  input  wire tgp_cmd_t          cmd,
  output tgp_stat_t              stat,
  output logic                   valid,
  output logic [ROW_W-1:0]       row_bits,
  output logic [4:0]             row_number,
  output logic                   last
);

  localparam int GRID_EFF = (GRID_SIZE < ROW_W) ? GRID_SIZE : ROW_W;
  localparam int IDX_W    = $clog2(GRID_EFF);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_EFF - 1);

  logic [ROW_W-1:0]  canvas [GRID_EFF];
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col_next;
  logic [IDX_W-1:0]  row_next;
  logic [1:0]        heading;
  logic              pen;
  logic [DIST_W-1:0] steps;
  logic [IDX_W-1:0]  rcnt;
  logic              blocked;

  // Next cell in the heading direction; hold at the canvas edge
  always_comb begin
    col_next = col;
    row_next = row;
    blocked  = 1'b0;
    case (heading)
      HEAD_EAST: begin
        if (col == LAST_IDX) blocked = 1'b1;
        else col_next = col + 1'b1;
      end
      HEAD_SOUTH: begin
        if (row == LAST_IDX) blocked = 1'b1;
        else row_next = row + 1'b1;
      end
      HEAD_WEST: begin
        if (col == '0) blocked = 1'b1;
        else col_next = col - 1'b1;
      end
      default: begin
        if (row == '0) blocked = 1'b1;
        else row_next = row - 1'b1;
      end
    endcase
  end

  assign stat.blocked    = blocked;
  assign stat.final_step = (steps == DIST_W'(1));
  assign stat.final_row  = (rcnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      heading <= HEAD_EAST;
      pen     <= 1'b0;
    end else begin
      if (cmd.set_pen) pen <= cmd.pen_val;
      if (cmd.turn_inc) heading <= heading + 2'd1;
      if (cmd.turn_dec) heading <= heading - 2'd1;
      if (cmd.step && !blocked) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_steps) begin
      steps <= distance;
    end else if (cmd.step) begin
      steps <= steps - DIST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GRID_EFF; i++) begin
        canvas[i] <= '0;
      end
    end else if (cmd.step && !blocked && pen) begin
      canvas[row_next][5'(col_next)] <= 1'b1;
    end
  end

  // Print: one row per cycle, counter wraps back to the top row
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt  <= '0;
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit_row;
      if (cmd.emit_row) begin
        rcnt <= stat.final_row ? '0 : rcnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_row) begin
      row_bits   <= canvas[rcnt];
      row_number <= 5'(rcnt);
      last       <= stat.final_row;
    end
  end

endmodule

`default_nettype wire

### design/turtle_grid_plotter.sv
// Turtle plotter on a square bit canvas of min(GRID_SIZE, 32) rows and columns.
// A request is taken when start is high and busy is low. Pen and turn
// requests complete in the cycle they are taken and never raise busy. Forward
// steps one cell per clock while busy is high, for up to distance cells, fewer
// when the turtle meets the edge; a zero distance finishes at once. Print reads
// one canvas row per clock and shows it on row_bits/row_number for a single
// cycle with valid high; the final row (with last set) appears in the first
// cycle with busy low. The receiver cannot stall: every row must be taken in
// the cycle valid is high. Reset clears the canvas, puts the turtle at the
// top-left cell facing east with the pen up.
`default_nettype none

module turtle_grid_plotter
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 32
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        mode,
  input  wire logic [DIST_W-1:0] distance,
  output logic                   valid,
  output logic [ROW_W-1:0]       row_bits,
  output logic [4:0]             row_number,
  output logic                   last
);

  tgp_cmd_t  cmd;
  tgp_stat_t stat;

  tgp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mode     (mode),
    .distance (distance),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  tgp_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .distance   (distance),
    .cmd        (cmd),
    .stat       (stat),
    .valid      (valid),
    .row_bits   (row_bits),
    .row_number (row_number),
    .last       (last)
  );

endmodule

`default_nettype wire

### design/tgp_checker.sv
`default_nettype none

module tgp_checker
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 32
)
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [2:0]        mode,
  input wire logic              valid,
  input wire logic [4:0]        row_number,
  input wire logic              last
);

  localparam int GRID_EFF = (GRID_SIZE < ROW_W) ? GRID_SIZE : ROW_W;

  // print request shows the top row once the state register has moved to print and the row outputs are registered
  a_print_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_PRINT) |-> ##2 (valid && row_number == 5'd0))
    else $error("print did not start at the top row");

  // rows of one print come back to back in order
  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> (valid && row_number == $past(row_number) + 5'd1))
    else $error("print rows not consecutive");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |-> (row_number == 5'(GRID_EFF - 1)))
    else $error("last flag on wrong row");

  a_busy_print: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |-> busy)
    else $error("new request possible mid print");

endmodule

bind turtle_grid_plotter tgp_checker #(.GRID_SIZE(GRID_SIZE)) u_tgp_checker (.*);

`default_nettype wire
